/* rtl/core/oli_pkg.sv */
package oli_pkg;

   // list storage
   localparam int CAPACITY = 256;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int POS_W    = 9;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int ITEM_W   = 9;

   typedef logic [OP_W-1:0]          op_type;
   typedef logic [STATUS_W-1:0]      status_type;
   typedef logic signed [DATA_W-1:0] data_type;

   localparam op_type OP_GET    = 2'd0;
   localparam op_type OP_INSERT = 2'd1;
   localparam op_type OP_APPEND = 2'd2;
   localparam op_type OP_DELETE = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

/* rtl/core/oli_if.sv */
interface oli_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [oli_pkg::OP_W-1:0]             operation;
   logic [oli_pkg::POS_W-1:0]            position;
   logic signed [oli_pkg::DATA_W-1:0]    value;

   modport source(output valid, operation, position, value, input ready);
   modport sink(input valid, operation, position, value, output ready);
endinterface

interface oli_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [oli_pkg::DATA_W-1:0]    read_value;
   logic [oli_pkg::STATUS_W-1:0]         status;
   logic [oli_pkg::ITEM_W-1:0]           item_count;

   modport source(output valid, read_value, status, item_count, input ready);
   modport sink(input valid, read_value, status, item_count, output ready);
endinterface

/* rtl/core/oli_ram.sv */
module oli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_en,
   input  logic [AW-1:0]    write_addr,
   input  logic [WIDTH-1:0] write_data,
   input  logic             read_en,
   input  logic [AW-1:0]    read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

/* rtl/core/ordered_list_insert_delete_unit.sv */
// Ordered list of signed 32-bit values with get, insert, append and delete
// by position. Requests arrive on req_chan (valid/ready), one result per
// request leaves on rsp_chan (valid/ready) with the value read, a status
// (ok, position out of range, list full) and the count after the request.
// The block works on one request at a time: req_chan.ready is high only
// while no request is in progress.
// Inserts and appends move the entries from the position to the end of
// the list one place up, one entry moved per cycle, then write the new
// value; a delete moves the entries above the position one place down.
// Rejected requests, gets, an insert/append at the end of the list and a
// delete of the last entry move nothing.
// The moves run through a single memory with one read and one write port,
// reading one entry ahead of the write, so the list length sets the worst
// case time per request.
// The result sits in an output register; while the receiver stalls, the
// next request is still accepted and worked on, and only its own result
// waits for the register to free up.
// Synchronous reset empties the list at once; stored entries are not
// cleared, as positions at or above the count are never read.
module ordered_list_insert_delete_unit (
   input  logic        clock,
   input  logic        reset,
   oli_req_if.sink     req_chan,
   oli_rsp_if.source   rsp_chan
);

   localparam int CNT_W  = oli_pkg::CNT_W;
   localparam int ADDR_W = oli_pkg::ADDR_W;
   localparam int CMP_W  = CNT_W + oli_pkg::POS_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GET   = 3'd1;
   localparam logic [2:0] S_UP    = 3'd2;
   localparam logic [2:0] S_DOWN  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           ptr_ff, ptr_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic                       pend_ff, pend_in;
   logic [ADDR_W-1:0]          waddr_ff, waddr_in;
   oli_pkg::data_type          val_ff, val_in;
   oli_pkg::data_type          data_ff, data_in;
   oli_pkg::status_type        status_ff, status_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   oli_pkg::data_type          rsp_data_ff, rsp_data_in;
   oli_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [oli_pkg::ITEM_W-1:0] rsp_count_ff, rsp_count_in;

   logic                       ram_we, ram_re;
   logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
   logic [oli_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

   logic                       accept;
   logic [CMP_W-1:0]           pos_x, count_x;
   logic [CNT_W-1:0]           ptr_dec, ptr_inc;
   logic                       out_free;
   logic [CNT_W+oli_pkg::ITEM_W-1:0] count_ext;

   oli_ram #(
      .WIDTH(oli_pkg::DATA_W),
      .DEPTH(oli_pkg::CAPACITY)
   ) u_ram (
      .clock     (clock),
      .write_en  (ram_we),
      .write_addr(ram_waddr),
      .write_data(ram_wdata),
      .read_en   (ram_re),
      .read_addr (ram_raddr),
      .read_data (ram_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign pos_x          = {{CNT_W{1'b0}}, req_chan.position};
   assign count_x        = {{oli_pkg::POS_W{1'b0}}, count_ff};
   assign ptr_dec        = ptr_ff - 1'b1;
   assign ptr_inc        = ptr_ff + 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign count_ext      = {{oli_pkg::ITEM_W{1'b0}}, count_ff};

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      pos_in    = pos_ff;
      pend_in   = 1'b0;
      waddr_in  = waddr_ff;
      val_in    = val_ff;
      data_in   = data_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_waddr = waddr_ff;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = ptr_dec[ADDR_W-1:0];

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in    = req_chan.value;
               data_in   = '0;
               status_in = oli_pkg::ST_OK;
               pos_in    = pos_x[CNT_W-1:0];
               case (req_chan.operation)
                  oli_pkg::OP_GET: begin
                     if (pos_x < count_x) begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_x[ADDR_W-1:0];
                        state_in  = S_GET;
                     end else begin
                        status_in = oli_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end
                  end
                  oli_pkg::OP_INSERT, oli_pkg::OP_APPEND: begin
                     ptr_in = count_ff;
                     if (req_chan.operation == oli_pkg::OP_APPEND) begin
                        pos_in = count_ff;
                     end
                     if (count_x >= CMP_W'(oli_pkg::CAPACITY)) begin
                        status_in = oli_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else if (req_chan.operation == oli_pkg::OP_INSERT
                                  && pos_x > count_x) begin
                        status_in = oli_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_UP;
                     end
                  end
                  default: begin
                     ptr_in = pos_x[CNT_W-1:0] + 1'b1;
                     if (pos_x >= count_x) begin
                        status_in = oli_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_DOWN;
                     end
                  end
               endcase
            end
         end
         S_GET: begin
            data_in  = ram_rdata;
            state_in = S_DONE;
         end
         S_UP: begin
            // read one below, write the previous read one above
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (ptr_ff > pos_ff) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_dec[ADDR_W-1:0];
               pend_in   = 1'b1;
               waddr_in  = ptr_ff[ADDR_W-1:0];
               ptr_in    = ptr_dec;
            end else if (!pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff[ADDR_W-1:0];
               ram_wdata = val_ff;
               count_in  = count_ff + 1'b1;
               state_in  = S_DONE;
            end
         end
         S_DOWN: begin
            if (pend_ff) begin
               ram_we = 1'b1;
            end
            if (ptr_ff < count_ff) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff[ADDR_W-1:0];
               pend_in   = 1'b1;
               waddr_in  = ptr_dec[ADDR_W-1:0];
               ptr_in    = ptr_inc;
            end else if (!pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = data_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ext[oli_pkg::ITEM_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      waddr_ff      <= waddr_in;
      val_ff        <= val_in;
      data_ff       <= data_in;
      status_ff     <= status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_data_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.item_count = rsp_count_ff;

endmodule

/* dv/tb_ordered_list_insert_delete_unit.sv */
`timescale 1ns / 100ps

module tb_ordered_list_insert_delete_unit;

   localparam int CAPACITY       = oli_pkg::CAPACITY;
   localparam int POS_W          = oli_pkg::POS_W;
   localparam int ITEM_W         = oli_pkg::ITEM_W;
   localparam int RESET_CYCLES   = 8;
   localparam int MAX_WAIT       = 9;
   localparam int DRAIN_CYCLES   = CAPACITY + 16;
   localparam int WATCHDOG_LIMIT = 8 * (CAPACITY + 16);

   typedef struct {
      oli_pkg::op_type   op;
      logic [POS_W-1:0]  pos;
      oli_pkg::data_type val;
   } list_request_type;

   typedef struct {
      oli_pkg::data_type   read_value;
      oli_pkg::status_type status;
      logic [ITEM_W-1:0]   item_count;
   } list_outcome_type;

   logic clock;
   logic reset;

   oli_req_if req_chan ();
   oli_rsp_if rsp_chan ();

   ordered_list_insert_delete_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   list_request_type  queued_requests[$];
   list_outcome_type  pending_outcomes[$];
   oli_pkg::data_type list_values[$];
   int                gen_count;
   int                error_count;
   int                req_gap;
   int                rsp_stall;
   int                idle_cycles;
   bit                steady_mode;
   list_request_type  next_req;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected result of one request, applied to the shadow list
   function automatic list_outcome_type apply_list_op(oli_pkg::op_type op,
                                                      logic [POS_W-1:0] pos,
                                                      oli_pkg::data_type val);
      list_outcome_type res;
      int unsigned fill;
      fill = list_values.size();
      res.read_value = '0;
      res.status     = oli_pkg::ST_OK;
      case (op)
         oli_pkg::OP_GET: begin
            if (pos < fill) res.read_value = list_values[pos];
            else res.status = oli_pkg::ST_RANGE;
         end
         oli_pkg::OP_INSERT, oli_pkg::OP_APPEND: begin
            // full check wins over a bad position
            if (fill >= CAPACITY) res.status = oli_pkg::ST_FULL;
            else if (op == oli_pkg::OP_INSERT && pos > fill) res.status = oli_pkg::ST_RANGE;
            else list_values.insert((op == oli_pkg::OP_APPEND) ? fill : int'(pos), val);
         end
         default: begin
            if (pos >= fill) res.status = oli_pkg::ST_RANGE;
            else list_values.delete(pos);
         end
      endcase
      res.item_count = ITEM_W'(list_values.size());
      return res;
   endfunction

   function automatic int draw_wait();
      return steady_mode ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // queue a request and track the fill level it leaves behind
   task automatic add_req(oli_pkg::op_type op, logic [POS_W-1:0] pos,
                          oli_pkg::data_type val);
      queued_requests.push_back('{op, pos, val});
      if (op == oli_pkg::OP_DELETE) begin
         if (pos < gen_count) gen_count--;
      end else if (op != oli_pkg::OP_GET) begin
         if (gen_count < CAPACITY && (op == oli_pkg::OP_APPEND || pos <= gen_count)) begin
            gen_count++;
         end
      end
   endtask

   task automatic add_random(int grow_pct, int shrink_pct);
      int                pick;
      oli_pkg::op_type   op;
      logic [POS_W-1:0]  pos;
      oli_pkg::data_type val;
      pick = $urandom_range(0, 99);
      if (pick < grow_pct) begin
         op = $urandom_range(0, 1) ? oli_pkg::OP_INSERT : oli_pkg::OP_APPEND;
      end else if (pick < grow_pct + shrink_pct) begin
         op = oli_pkg::OP_DELETE;
      end else begin
         op = oli_pkg::OP_GET;
      end
      // mostly in-range positions, with some noise across the whole field
      if ($urandom_range(0, 9) == 0 || op == oli_pkg::OP_APPEND) pos = POS_W'($urandom);
      else if (op == oli_pkg::OP_INSERT) pos = POS_W'($urandom_range(0, gen_count));
      else if (gen_count == 0) pos = '0;
      else pos = POS_W'($urandom_range(0, gen_count - 1));
      case ($urandom_range(0, 15))
         0: val = 32'h8000_0000;
         1: val = 32'h7FFF_FFFF;
         2: val = 32'h0000_0000;
         3: val = 32'hFFFF_FFFF;
         default: val = $urandom;
      endcase
      add_req(op, pos, val);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pending_outcomes.push_back(apply_list_op(req_chan.operation, req_chan.position,
                                                     req_chan.value));
            if ($urandom_range(0, 39) == 0) steady_mode = !steady_mode;
            req_gap = draw_wait();
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (req_gap > 0) begin
               req_chan.valid <= 1'b0;
               req_gap--;
            end else if (queued_requests.size() != 0) begin
               next_req = queued_requests.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.operation <= next_req.op;
               req_chan.position  <= next_req.pos;
               req_chan.value     <= next_req.val;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      list_outcome_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d", $time,
                        rsp_chan.read_value, rsp_chan.status, rsp_chan.item_count);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_chan.read_value !== want.read_value) begin
                  error_count++;
                  $display("%0t: read_value mismatch: expected %0d, actual %0d", $time,
                           want.read_value, rsp_chan.read_value);
               end
               if (rsp_chan.status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                           want.status, rsp_chan.status);
               end
               if (rsp_chan.item_count !== want.item_count) begin
                  error_count++;
                  $display("%0t: item_count mismatch: expected %0d, actual %0d", $time,
                           want.item_count, rsp_chan.item_count);
               end
            end
            rsp_stall = draw_wait();
         end
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // no progress while work is outstanding
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else if (queued_requests.size() != 0 || req_chan.valid ||
                      pending_outcomes.size() != 0) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("Regression FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.operation = oli_pkg::OP_GET;
      req_chan.position  = '0;
      req_chan.value     = '0;
      rsp_chan.ready     = 1'b0;
      gen_count          = 0;
      error_count        = 0;
      idle_cycles        = 0;
      steady_mode        = 1'b0;

      // empty list corner cases
      add_req(oli_pkg::OP_GET,    9'd0,   32'd0);
      add_req(oli_pkg::OP_DELETE, 9'd0,   32'd0);
      add_req(oli_pkg::OP_INSERT, 9'd1,   32'd5);
      // build a short list at front, end and middle
      add_req(oli_pkg::OP_INSERT, 9'd0,   32'h8000_0000);
      add_req(oli_pkg::OP_APPEND, 9'h1FF, 32'h7FFF_FFFF);
      add_req(oli_pkg::OP_INSERT, 9'd1,   32'h0000_0000);
      add_req(oli_pkg::OP_INSERT, 9'd3,   32'hFFFF_FFFF);
      add_req(oli_pkg::OP_INSERT, 9'd0,   32'h5555_5555);
      add_req(oli_pkg::OP_INSERT, 9'd2,   32'hAAAA_AAAA);
      add_req(oli_pkg::OP_GET,    9'd0,   32'h1234_5678);
      add_req(oli_pkg::OP_GET,    9'd5,   32'd0);
      add_req(oli_pkg::OP_GET,    9'd6,   32'd0);
      add_req(oli_pkg::OP_GET,    9'h1FF, 32'd0);
      // insert past the end, then deletes, gets and an append
      add_req(oli_pkg::OP_INSERT, 9'd7,   32'd7);
      add_req(oli_pkg::OP_INSERT, 9'h1FF, 32'h0F0F_0F0F);
      add_req(oli_pkg::OP_DELETE, 9'd6,   32'd0);
      add_req(oli_pkg::OP_DELETE, 9'h1FF, 32'd0);
      add_req(oli_pkg::OP_DELETE, 9'd2,   32'd0);
      add_req(oli_pkg::OP_DELETE, 9'd0,   32'd0);
      add_req(oli_pkg::OP_DELETE, 9'd3,   32'd0);
      add_req(oli_pkg::OP_GET,    9'd0,   32'd0);
      add_req(oli_pkg::OP_GET,    9'd2,   32'd0);
      add_req(oli_pkg::OP_APPEND, 9'd0,   32'd1);

      // grow to full
      while (gen_count < CAPACITY) add_random(95, 3);
      // full list, including a bad position on a full list
      add_req(oli_pkg::OP_INSERT, 9'h1FF, 32'h0BAD_0BAD);
      add_req(oli_pkg::OP_APPEND, 9'd0,   32'h7FFF_FFFF);
      add_req(oli_pkg::OP_INSERT, 9'd0,   32'h8000_0000);
      add_req(oli_pkg::OP_GET,    POS_W'(CAPACITY - 1), 32'd0);
      add_req(oli_pkg::OP_GET,    POS_W'(CAPACITY),     32'd0);
      add_req(oli_pkg::OP_DELETE, POS_W'(CAPACITY - 1), 32'd0);
      add_req(oli_pkg::OP_APPEND, 9'd0,   32'hFFFF_FFFF);
      repeat (30) add_random(50, 15);
      // drain to empty
      while (gen_count > 0) add_random(3, 95);
      repeat (20) add_random(40, 30);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (queued_requests.size() != 0 || req_chan.valid || pending_outcomes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
